// ===== hdl/tscv_pkg.sv =====
// Shared constants, widths and helper functions for the touch strip smoother.
package tscv_pkg;

  localparam int PAD_COUNT = 12;
  localparam int PADS_W    = 12;
  localparam int DEV_W     = 16;
  localparam int TOP_W     = 4;
  localparam int Q_W       = 17;
  localparam int FS_W      = 15;
  localparam int ACC_W     = 34;
  localparam int MCAND_W   = 33;

  localparam int PAD_SCAN  = (PAD_COUNT < PADS_W) ? PAD_COUNT : PADS_W;

  localparam logic [Q_W-1:0] Q_ONE      = 17'd65536;
  localparam logic [Q_W-1:0] Q_HALF     = 17'd32768;
  localparam logic [Q_W-1:0] SMOOTH_MAX = 17'd62259;

  localparam int MUL_STEPS = 17;
  localparam int DIV_STEPS = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_DECAY = 2'd2;

  localparam logic [FS_W-1:0] FULL_SCALE_RST = 15'd50;
  localparam logic [Q_W-1:0]  POS_WEIGHT_RST = 17'd45875;
  localparam logic [Q_W-1:0]  IDLE_DECAY_RST = 17'd62259;

  // Saturate an 18-bit value to one in Q1.16.
  function automatic logic [Q_W-1:0] sat_q(input logic [Q_W:0] x);
    return (x > {1'b0, Q_ONE}) ? Q_ONE : x[Q_W-1:0];
  endfunction

  // Pad position as a Q1.16 fraction of the strip, rounded to nearest.
  // Each entry is worked out from constants, so this is a small lookup table.
  function automatic logic [Q_W-1:0] pos_of(input logic [TOP_W-1:0] idx);
    logic [Q_W-1:0] pos;
    int             val;
    pos = '0;
    for (int i = 0; i < (1 << TOP_W); i++) begin
      val = (i * 65536 + (PAD_COUNT - 1) / 2) / (PAD_COUNT - 1);
      if (idx == TOP_W'(i)) pos = sat_q((Q_W+1)'(val));
    end
    return pos;
  endfunction

endpackage

// ===== hdl/touch_strip_cv_smoother_core.sv =====
// Touch strip control-value smoother: bit-serial multiply and divide sequencer.
// Untouched poll: one 17-step serial multiply (the idle decay), then a finish step. Touched:
// the 16-step serial divide when the pressure needs it, then the square, mix and blend
// multiplies, a coefficient and a finish step; the multiplier takes one bit a cycle.
// One transaction at a time: the next is taken once the result is in the output register,
// even if that result is still waiting. Synchronous active-low reset restores the register
// defaults, clears the value and empties the output.
module touch_strip_cv_smoother_core
  import tscv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Poll input. in_tdata, from bit 0: touched_pads[11:0], pad_deviation[27:12], zero fill.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,
  // Result. out_tdata, from bit 0: cv_level[16:0], top_pad[20:17], zero fill.
  // out_tuser, from bit 0: any_touched.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,
  output logic                 out_tuser,
  // Register write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [Q_W-1:0]       cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SQ, ST_MIX1, ST_MIX2, ST_COEF, ST_NEW1, ST_NEW2, ST_DECAY, ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [FS_W-1:0] full_scale_r, full_scale_nxt;
  logic [Q_W-1:0]  weight_r, weight_nxt;
  logic [Q_W-1:0]  decay_r, decay_nxt;

  // Stored control value.
  logic [Q_W-1:0]  smoothed_r, smoothed_nxt;

  // Shared serial multiplier: acc += mcand * mplier, one multiplier bit per cycle.
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [MCAND_W-1:0] mcand_r, mcand_nxt;
  logic [Q_W-1:0]     mplier_r, mplier_nxt;
  logic [4:0]         cnt_r, cnt_nxt;

  // Serial restoring divider for the pressure fraction.
  logic [FS_W-1:0] rem_r, rem_nxt;
  logic [15:0]     num_r, num_nxt;
  logic [15:0]     quo_r, quo_nxt;

  // Intermediate values of one transaction.
  logic [TOP_W-1:0] top_r, top_nxt;
  logic             any_r, any_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [Q_W-1:0]   m_r, m_nxt;
  logic [Q_W-1:0]   s_r, s_nxt;
  logic [Q_W-1:0]   res_r, res_nxt;

  // Output stage.
  logic             out_valid_r, out_valid_nxt;
  logic [Q_W-1:0]   out_cv_r, out_cv_nxt;
  logic [TOP_W-1:0] out_top_r, out_top_nxt;
  logic             out_any_r, out_any_nxt;

  logic [PADS_W-1:0]  pads_in;
  logic [DEV_W-1:0]   dev_in;
  logic [TOP_W-1:0]   top_in;
  logic               any_in;
  logic [FS_W-1:0]    fs_eff;
  logic [Q_W-1:0]     w_sat;
  logic [Q_W-1:0]     d_sat;
  logic [ACC_W-1:0]   acc_add;
  logic               mul_last;
  logic               div_last;
  logic [15:0]        div_trial;
  logic               div_ge;
  logic [Q_W-1:0]     diff;
  logic [Q_W:0]       diff2;
  logic [Q_W-1:0]     s_val;
  logic               in_fire;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_top_r, out_cv_r};
  assign out_tuser  = out_any_r;

  assign pads_in = in_tdata[PADS_W-1:0];
  assign dev_in  = in_tdata[PADS_W+DEV_W-1:PADS_W];

  // Highest touched pad among those on the strip; mask bits beyond the strip are ignored.
  always_comb begin
    top_in = '0;
    any_in = 1'b0;
    for (int i = 0; i < PAD_SCAN; i++) begin
      if (pads_in[i]) begin
        top_in = TOP_W'(i);
        any_in = 1'b1;
      end
    end
  end

  // A zero full scale acts as one; weight and decay above one saturate.
  assign fs_eff = (full_scale_r == '0) ? FS_W'(1) : full_scale_r;
  assign w_sat  = (weight_r > Q_ONE) ? Q_ONE : weight_r;
  assign d_sat  = (decay_r > Q_ONE) ? Q_ONE : decay_r;

  assign acc_add  = acc_r + (mplier_r[0] ? {1'b0, mcand_r} : '0);
  assign mul_last = (cnt_r == 5'(MUL_STEPS - 1));
  assign div_last = (cnt_r == 5'(DIV_STEPS - 1));

  // One quotient bit per cycle; the remainder always stays below the full scale.
  assign div_trial = {rem_r, num_r[15]};
  assign div_ge    = (div_trial >= {1'b0, fs_eff});

  // Smoothing coefficient: max(one half, 0.95 - 2*|mix - value|).
  assign diff  = (m_r >= smoothed_r) ? (m_r - smoothed_r) : (smoothed_r - m_r);
  assign diff2 = {diff, 1'b0};
  assign s_val = (diff2 >= {1'b0, SMOOTH_MAX - Q_HALF}) ? Q_HALF
               : Q_W'({1'b0, SMOOTH_MAX} - diff2);

  always_comb begin
    state_nxt      = state_r;
    full_scale_nxt = full_scale_r;
    weight_nxt     = weight_r;
    decay_nxt      = decay_r;
    smoothed_nxt   = smoothed_r;
    acc_nxt        = acc_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    num_nxt        = num_r;
    quo_nxt        = quo_r;
    top_nxt        = top_r;
    any_nxt        = any_r;
    q_nxt          = q_r;
    m_nxt          = m_r;
    s_nxt          = s_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cv_nxt     = out_cv_r;
    out_top_nxt    = out_top_r;
    out_any_nxt    = out_any_r;

    if (cfg_valid) begin
      unique case (cfg_addr)
        REG_FULL_SCALE: full_scale_nxt = cfg_data[FS_W-1:0];
        REG_POS_WEIGHT: weight_nxt     = cfg_data;
        REG_IDLE_DECAY: decay_nxt      = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          top_nxt = top_in;
          any_nxt = any_in;
          cnt_nxt = '0;
          if (!any_in) begin
            mcand_nxt  = MCAND_W'(smoothed_r);
            mplier_nxt = d_sat;
            acc_nxt    = '0;
            state_nxt  = ST_DECAY;
          end else if (dev_in[DEV_W-1] || dev_in == '0) begin
            mcand_nxt  = '0;
            mplier_nxt = '0;
            acc_nxt    = ACC_W'(Q_HALF);
            state_nxt  = ST_SQ;
          end else if (dev_in[FS_W-1:0] >= fs_eff) begin
            mcand_nxt  = MCAND_W'(Q_ONE);
            mplier_nxt = Q_ONE;
            acc_nxt    = ACC_W'(Q_HALF);
            state_nxt  = ST_SQ;
          end else begin
            rem_nxt   = dev_in[FS_W-1:0];
            num_nxt   = {2'b00, fs_eff[FS_W-1:1]};
            quo_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? FS_W'(div_trial - {1'b0, fs_eff}) : div_trial[FS_W-1:0];
        num_nxt = {num_r[14:0], 1'b0};
        quo_nxt = {quo_r[14:0], div_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (div_last) begin
          mcand_nxt  = MCAND_W'(quo_nxt);
          mplier_nxt = Q_W'(quo_nxt);
          acc_nxt    = ACC_W'(Q_HALF);
          cnt_nxt    = '0;
          state_nxt  = ST_SQ;
        end
      end
      ST_SQ, ST_MIX1, ST_MIX2, ST_NEW1, ST_NEW2, ST_DECAY: begin
        acc_nxt    = acc_add;
        mcand_nxt  = {mcand_r[MCAND_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[Q_W-1:1]};
        cnt_nxt    = cnt_r + 5'd1;
        if (mul_last) begin
          cnt_nxt = '0;
          unique case (state_r)
            ST_SQ: begin
              q_nxt      = sat_q(acc_add[ACC_W-1:16]);
              mcand_nxt  = MCAND_W'(pos_of(top_r));
              mplier_nxt = w_sat;
              acc_nxt    = ACC_W'(Q_HALF);
              state_nxt  = ST_MIX1;
            end
            ST_MIX1: begin
              // The pressure term adds onto the same accumulator.
              mcand_nxt  = MCAND_W'(q_r);
              mplier_nxt = Q_ONE - w_sat;
              state_nxt  = ST_MIX2;
            end
            ST_MIX2: begin
              m_nxt     = sat_q(acc_add[ACC_W-1:16]);
              state_nxt = ST_COEF;
            end
            ST_NEW1: begin
              mcand_nxt  = MCAND_W'(m_r);
              mplier_nxt = Q_ONE - s_r;
              state_nxt  = ST_NEW2;
            end
            default: begin
              // Final blend, or the idle decay which starts from zero and so truncates.
              res_nxt   = sat_q(acc_add[ACC_W-1:16]);
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_COEF: begin
        s_nxt      = s_val;
        mcand_nxt  = MCAND_W'(smoothed_r);
        mplier_nxt = s_val;
        acc_nxt    = ACC_W'(Q_HALF);
        cnt_nxt    = '0;
        state_nxt  = ST_NEW1;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          smoothed_nxt  = res_r;
          out_cv_nxt    = res_r;
          out_top_nxt   = top_r;
          out_any_nxt   = any_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      full_scale_r <= FULL_SCALE_RST;
      weight_r     <= POS_WEIGHT_RST;
      decay_r      <= IDLE_DECAY_RST;
      smoothed_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      full_scale_r <= full_scale_nxt;
      weight_r     <= weight_nxt;
      decay_r      <= decay_nxt;
      smoothed_r   <= smoothed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    num_r     <= num_nxt;
    quo_r     <= quo_nxt;
    top_r     <= top_nxt;
    any_r     <= any_nxt;
    q_r       <= q_nxt;
    m_r       <= m_nxt;
    s_r       <= s_nxt;
    res_r     <= res_nxt;
    out_cv_r  <= out_cv_nxt;
    out_top_r <= out_top_nxt;
    out_any_r <= out_any_nxt;
  end

  // The stored value never leaves the range zero to one.
  a_smoothed_range: assert property (@(posedge clk) disable iff (!rst_n)
    smoothed_r <= Q_ONE) else $error("smoothed value above one");

  // An idle result reports pad zero.
  a_idle_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_any_r |-> out_top_r == '0) else $error("idle result with pad index");

  // A taken transaction starts a computation; no second one enters behind it.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("input taken twice in a row");

  // A new result only appears at the end of a computation.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN) else $error("result outside finish step");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the touch strip control-value smoother core.
module testbench;
  import tscv_pkg::*;

  // An index that the register file does not decode; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int TIMEOUT_UNITS = 40_000_000;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [Q_W-1:0]   level;
    logic [TOP_W-1:0] top;
    logic             touched;
  } cv_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [Q_W-1:0]       cfg_data;

  // Shadow copy of the block's registers and its smoothed value, updated at each transaction.
  logic [FS_W-1:0] shadow_full_scale;
  logic [Q_W-1:0]  shadow_weight;
  logic [Q_W-1:0]  shadow_decay;
  logic [Q_W-1:0]  shadow_level;

  cv_result_t cv_expected[$];
  int         mismatch_count = 0;
  int         hold_cycles = 0;
  bit         tx_jitter = 1'b1;
  bit         rx_jitter = 1'b1;

  touch_strip_cv_smoother_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Safety net: a correct run ends long before this.
  initial begin
    #(TIMEOUT_UNITS);
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint unsigned clip_unity(input longint unsigned x);
    return (x > Q_ONE) ? longint'(Q_ONE) : x;
  endfunction

  // Random gap length; about one in ten is a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Computes the result of one poll and advances the shadow smoothed value.
  function automatic cv_result_t predict_cv(input logic [PADS_W-1:0] pads,
                                            input logic [DEV_W-1:0] dev_bits);
    longint            dev;
    longint            diff;
    longint            coef;
    longint unsigned   v;
    longint unsigned   scale;
    longint unsigned   p;
    longint unsigned   q;
    longint unsigned   pos;
    longint unsigned   w;
    longint unsigned   mix;
    longint unsigned   nv;
    int                top;
    cv_result_t        r;
    dev = longint'($signed(dev_bits));
    v = shadow_level;
    top = -1;
    // Only the pads that exist on the strip count; the highest set one wins.
    for (int i = 0; i < PAD_COUNT && i < PADS_W; i++) begin
      if (pads[i]) top = i;
    end

    if (top < 0) begin
      // Idle poll: truncating decay, so small values reach zero.
      scale = clip_unity(shadow_decay);
      nv = clip_unity((v * scale) >> 16);
      r.top = '0;
      r.touched = 1'b0;
    end else begin
      scale = (shadow_full_scale == 0) ? 1 : shadow_full_scale;
      if (dev <= 0) p = 0;
      else if (u64_t'(dev) >= scale) p = Q_ONE;
      else p = ((u64_t'(dev) << 16) + scale / 2) / scale;
      q = (p * p + Q_HALF) >> 16;
      pos = clip_unity((u64_t'(top) * Q_ONE + (PAD_COUNT - 1) / 2) /
                       (PAD_COUNT - 1));
      w = clip_unity(shadow_weight);
      mix = clip_unity((pos * w + q * (Q_ONE - w) + Q_HALF) >> 16);
      // The smoothing eases off when the target jumps far from the current value.
      diff = longint'(mix) - longint'(v);
      if (diff < 0) diff = -diff;
      coef = longint'(SMOOTH_MAX) - 2 * diff;
      if (coef < longint'(Q_HALF)) coef = Q_HALF;
      nv = clip_unity((v * u64_t'(coef) +
                       mix * (Q_ONE - u64_t'(coef)) + Q_HALF) >> 16);
      r.top = TOP_W'(top);
      r.touched = 1'b1;
    end
    shadow_level = nv[Q_W-1:0];
    r.level = nv[Q_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d, at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Offers one poll and waits for the transaction; valid stays high when no gap follows.
  task automatic send_poll(input logic [PADS_W-1:0] pads, input logic [DEV_W-1:0] dev);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, dev, pads};
    do @(posedge clk); while (!in_tready);
    cv_expected.push_back(predict_cv(pads, dev));
    if (tx_jitter && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Stops offering polls and waits until every predicted result has been taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (cv_expected.size() != 0);
  endtask

  // Register writes are only issued from a drained, idle block.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FULL_SCALE: shadow_full_scale = data[FS_W-1:0];
      REG_POS_WEIGHT: shadow_weight = data;
      REG_IDLE_DECAY: shadow_decay = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic restore_defaults();
    wait_drained();
    write_reg(REG_FULL_SCALE, 17'(FULL_SCALE_RST));
    write_reg(REG_POS_WEIGHT, POS_WEIGHT_RST);
    write_reg(REG_IDLE_DECAY, IDLE_DECAY_RST);
  endtask

  // Receiver pacing: random stalls when enabled, plus a long hold on request.
  initial begin : rx_pacing
    int n;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Every result transaction is checked field by field against the oldest prediction.
  always @(posedge clk) begin : result_check
    cv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cv_expected.size() == 0) begin
        report_mismatch("result with no poll pending", out_tdata[Q_W-1:0], 0);
      end else begin
        want = cv_expected.pop_front();
        if (out_tdata[Q_W-1:0] !== want.level)
          report_mismatch("cv_level", out_tdata[Q_W-1:0], want.level);
        if (out_tdata[Q_W+TOP_W-1:Q_W] !== want.top)
          report_mismatch("top_pad", out_tdata[Q_W+TOP_W-1:Q_W], want.top);
        if (out_tuser !== want.touched)
          report_mismatch("any_touched", out_tuser, want.touched);
      end
    end
  end

  // Field extremes and the pressure edge cases under the reset register values.
  task automatic test_directed_polls();
    tx_jitter = 1'b0;
    send_poll(12'h000, 16'h0000);   // idle from a zero value
    send_poll(12'h000, 16'h7FFF);   // idle ignores the deviation
    send_poll(12'h001, 16'h7FFF);   // lowest pad, full pressure
    send_poll(12'h800, 16'h8000);   // highest pad, most negative deviation
    send_poll(12'hFFF, 16'h0000);   // every pad, the top one wins
    send_poll(12'h001, 16'h0001);
    send_poll(12'h002, 16'd25);     // half of full scale
    send_poll(12'h004, 16'd49);
    send_poll(12'h008, 16'd50);     // exactly full scale
    send_poll(12'h010, 16'd51);
    for (int pad = 5; pad < 11; pad++) send_poll(12'(1) << pad, 16'hFFFF);
    send_poll(12'h7FF, 16'h4000);
    for (int i = 0; i < 4; i++) send_poll(12'h000, 16'($urandom));
    tx_jitter = 1'b1;
  endtask

  // Each register at its extremes, with a few polls that show the effect.
  task automatic test_register_extremes();
    wait_drained();
    write_reg(REG_FULL_SCALE, 17'd0);        // zero full scale acts as one
    send_poll(12'h020, 16'd1);
    send_poll(12'h020, 16'd0);
    wait_drained();
    write_reg(REG_FULL_SCALE, 17'h1FFFF);    // only 15 bits are kept
    send_poll(12'h040, 16'd16384);
    send_poll(12'h040, 16'h7FFF);
    wait_drained();
    write_reg(REG_FULL_SCALE, 17'd1);
    send_poll(12'h100, 16'd1);
    wait_drained();
    write_reg(REG_POS_WEIGHT, 17'd0);
    send_poll(12'h400, 16'd3);
    wait_drained();
    write_reg(REG_POS_WEIGHT, 17'd65536);
    send_poll(12'h200, 16'h7FFF);
    wait_drained();
    write_reg(REG_POS_WEIGHT, 17'h1FFFF);    // weight above one saturates
    send_poll(12'h080, 16'd0);
    wait_drained();
    write_reg(REG_IDLE_DECAY, 17'd65536);
    send_poll(12'h800, 16'h7FFF);
    send_poll(12'h000, 16'd0);
    wait_drained();
    write_reg(REG_IDLE_DECAY, 17'h1FFFF);    // decay above one saturates
    send_poll(12'h000, 16'd0);
    wait_drained();
    write_reg(REG_IDLE_DECAY, 17'd0);
    send_poll(12'h000, 16'd0);
    wait_drained();
    // An unmapped index must leave all three registers alone.
    write_reg(REG_UNMAPPED, 17'($urandom));
    send_poll(12'h010, 16'd20);
    send_poll(12'h000, 16'd0);
    restore_defaults();
  endtask

  task automatic randomize_registers();
    logic [Q_W-1:0] fs;
    wait_drained();
    case ($urandom_range(0, 4))
      0: fs = 17'd0;
      1: fs = 17'd1;
      2: fs = 17'h7FFF;
      3: fs = 17'($urandom_range(2, 400));
      default: fs = 17'($urandom);
    endcase
    write_reg(REG_FULL_SCALE, fs);
    case ($urandom_range(0, 3))
      0: write_reg(REG_POS_WEIGHT, 17'd0);
      1: write_reg(REG_POS_WEIGHT, 17'd65536);
      2: write_reg(REG_POS_WEIGHT, 17'($urandom));
      default: write_reg(REG_POS_WEIGHT, 17'($urandom_range(0, 65536)));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(REG_IDLE_DECAY, 17'd0);
      1: write_reg(REG_IDLE_DECAY, 17'd65536);
      2: write_reg(REG_IDLE_DECAY, 17'($urandom));
      default: write_reg(REG_IDLE_DECAY, 17'($urandom_range(40000, 65536)));
    endcase
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNMAPPED, 17'($urandom));
  endtask

  // Mostly finger gestures: a run of touches that drifts across neighboring pads with
  // deviations near full scale, then a release of idle polls. The rest is raw noise.
  task automatic run_gestures(input int n_items);
    int sent;
    int len;
    int pad;
    int fs_eff;
    int dev;
    logic [PADS_W-1:0] mask;
    sent = 0;
    while (sent < n_items) begin
      fs_eff = (shadow_full_scale == 0) ? 1 : shadow_full_scale;
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 24);
        pad = $urandom_range(0, PAD_COUNT - 1);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 3))
            0: if (pad > 0) pad--;
            1: if (pad < PAD_COUNT - 1) pad++;
            default: ;
          endcase
          mask = 12'(1) << pad;
          if ($urandom_range(0, 2) == 0) mask |= 12'($urandom) & (mask - 12'(1));
          if ($urandom_range(0, 7) == 0) dev = -$urandom_range(1, 32768);
          else dev = $urandom_range(0, (2 * fs_eff < 32767) ? 2 * fs_eff : 32767);
          send_poll(mask, 16'(dev));
        end
        sent += len;
        len = $urandom_range(0, 12);
        for (int i = 0; i < len; i++) send_poll(12'h000, 16'($urandom));
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) send_poll(12'($urandom), 16'($urandom));
      end
      sent += len;
    end
  endtask

  task automatic test_random_polls();
    for (int phase = 0; phase < 6; phase++) begin
      randomize_registers();
      // Two phases run with one side never idling.
      tx_jitter = (phase != 2);
      rx_jitter = (phase != 3);
      run_gestures(300);
    end
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
  endtask

  // The receiver holds off while polls keep coming, so the block must stall its input.
  task automatic test_output_backpressure();
    restore_defaults();
    tx_jitter = 1'b0;
    hold_cycles = 600;
    for (int i = 0; i < 10; i++)
      send_poll(12'($urandom_range(1, 4095)), 16'($urandom_range(0, 80)));
    tx_jitter = 1'b1;
    wait_drained();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_addr  = '0;
    cfg_data  = '0;
    shadow_full_scale = FULL_SCALE_RST;
    shadow_weight     = POS_WEIGHT_RST;
    shadow_decay      = IDLE_DECAY_RST;
    shadow_level      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_polls();
    test_register_extremes();
    test_random_polls();
    test_output_backpressure();

    wait_drained();
    repeat (120) @(posedge clk);
    if (cv_expected.size() != 0) report_mismatch("results never delivered", cv_expected.size(), 0);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tscv_pkg.sv
hdl/touch_strip_cv_smoother_core.sv
test/testbench.sv
